>>> hw/rtl/shell_sort_pratt_gaps_top_defines.svh
// assertion helpers for the shell sort block
`ifndef SHELL_SORT_PRATT_GAPS_TOP_DEFINES_SVH
`define SHELL_SORT_PRATT_GAPS_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SSPG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sspg: same-cycle check failed");

// next-cycle implication
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sspg: next-cycle check failed");

// delayed implication, |=> with a further ## delay
`define SSPG_ASSERT_LATER(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error("sspg: two-cycle check failed");

`else

`define SSPG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SSPG_ASSERT_NEXT(label, clk, rst, ante, cons)
`define SSPG_ASSERT_LATER(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/sspg_pkg.sv
package sspg_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;

   // command kinds
   localparam kind_type KIND_PUSH  = 2'd0;
   localparam kind_type KIND_SORT  = 2'd1;
   localparam kind_type KIND_READ  = 2'd2;
   localparam kind_type KIND_CLEAR = 2'd3;

   // result status codes
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FULL  = 2'd1;
   localparam status_type STAT_EMPTY = 2'd2;

   typedef struct packed {
      kind_type           kind;
      logic signed [63:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value_out;
      logic [31:0]        shift_count;
      logic               last_element;
      status_type         status;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic do_push;
      logic do_clear;
      logic rd_issue;
      logic rd_finish;
      logic srt_init;
      logic smooth_step;
      logic gap_dec;
      logic j_init;
      logic j_adv;
      logic rd_j;
      logic held_load;
      logic cmp_step;
      logic put;
      logic srt_finish;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic few;
      logic r_one;
      logic r_even;
      logic r_div3;
      logic gap_one;
      logic greater;
      logic more;
      logic j_last;
   } dp_stat_type;

endpackage

>>> hw/rtl/sspg_dp.sv
module sspg_dp #(
   parameter int DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sspg_pkg::dp_cmd_type cmd,
   output sspg_pkg::dp_stat_type stat,
   input  logic signed [63:0]   push_value,
   output logic                 rsp_valid,
   output sspg_pkg::rsp_type    rsp_data
);
   import sspg_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   // reciprocal of three for exact division of AW-bit values
   localparam int DS = AW + 2;
   localparam int MW = DS - 1;
   localparam int PW = AW + MW;
   localparam logic [MW-1:0] RECIP3 = MW'((2 ** DS) / 3 + 1);

   logic signed [63:0] store_ff [DEPTH];
   logic signed [63:0] rdata_ff;
   logic signed [63:0] held_ff, held_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rptr_ff, rptr_in;
   logic [AW-1:0]      gap_ff, gap_in;
   logic [AW-1:0]      r_ff, r_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [31:0]        shift_ff, shift_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [AW-1:0]      im, im2, raddr, waddr;
   logic               we;
   logic signed [63:0] wdata;
   logic [PW-1:0]      prod;
   logic [AW-1:0]      q3;
   logic [AW+1:0]      t3;
   logic               full, rd_ok;

   // neighbor addresses one and two gaps down
   assign im  = i_ff - gap_ff;
   assign im2 = im - gap_ff;

   // divide by three through the reciprocal, then check exactness
   assign prod = PW'(r_ff) * PW'(RECIP3);
   assign q3   = AW'(prod >> DS);
   assign t3   = (AW+2)'(q3) + ((AW+2)'(q3) << 1);

   assign full  = (count_ff == CW'(DEPTH));
   assign rd_ok = (rptr_ff < count_ff);

   // status toward the controller
   always_comb begin
      stat.few     = (count_ff < CW'(2));
      stat.r_one   = (r_ff == AW'(1));
      stat.r_even  = !r_ff[0];
      stat.r_div3  = (t3 == (AW+2)'(r_ff));
      stat.gap_one = (gap_ff == AW'(1));
      stat.greater = (rdata_ff > held_ff);
      stat.more    = (im >= gap_ff);
      stat.j_last  = ((CW'(j_ff) + CW'(1)) == count_ff);
   end

   // read address select
   always_comb begin
      raddr = '0;
      if (cmd.rd_issue) begin
         raddr = rptr_ff[AW-1:0];
      end else if (cmd.held_load) begin
         raddr = j_ff - gap_ff;
      end else if (cmd.cmp_step) begin
         raddr = im2;
      end else if (cmd.rd_j) begin
         raddr = j_ff;
      end
   end

   // write port select
   always_comb begin
      we    = 1'b0;
      waddr = i_ff;
      wdata = held_ff;
      if (cmd.do_push && !full) begin
         we    = 1'b1;
         waddr = count_ff[AW-1:0];
         wdata = push_value;
      end else if (cmd.cmp_step) begin
         we    = 1'b1;
         wdata = stat.greater ? rdata_ff : held_ff;
      end else if (cmd.put) begin
         we    = 1'b1;
      end
   end

   // element store, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   // sort and pointer registers
   always_comb begin
      count_in = count_ff;
      rptr_in  = rptr_ff;
      gap_in   = gap_ff;
      r_in     = r_ff;
      j_in     = j_ff;
      i_in     = i_ff;
      held_in  = held_ff;
      shift_in = shift_ff;
      if (cmd.do_push && !full) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.do_clear) begin
         count_in = '0;
         rptr_in  = '0;
      end
      if (cmd.rd_finish && rd_ok) begin
         rptr_in = rptr_ff + CW'(1);
      end
      if (cmd.srt_finish) begin
         rptr_in = '0;
      end
      if (cmd.srt_init) begin
         gap_in   = AW'(count_ff - CW'(1));
         r_in     = AW'(count_ff - CW'(1));
         shift_in = '0;
      end
      if (cmd.smooth_step) begin
         r_in = stat.r_even ? (r_ff >> 1) : q3;
      end
      if (cmd.gap_dec) begin
         gap_in = gap_ff - AW'(1);
         r_in   = gap_ff - AW'(1);
      end
      if (cmd.j_init) begin
         j_in = gap_ff;
      end
      if (cmd.j_adv) begin
         j_in = j_ff + AW'(1);
      end
      if (cmd.held_load) begin
         held_in = rdata_ff;
         i_in    = j_ff;
      end
      if (cmd.cmp_step && stat.greater) begin
         i_in     = im;
         shift_in = (shift_ff == '1) ? shift_ff : shift_ff + 32'd1;
      end
   end

   // result beat
   always_comb begin
      rsp_valid_in = cmd.do_push | cmd.do_clear | cmd.rd_finish | cmd.srt_finish;
      rsp_in       = '0;
      if (cmd.do_push) begin
         rsp_in.status = full ? STAT_FULL : STAT_OK;
      end
      if (cmd.rd_finish) begin
         if (rd_ok) begin
            rsp_in.value_out    = rdata_ff;
            rsp_in.last_element = ((rptr_ff + CW'(1)) == count_ff);
         end else begin
            rsp_in.status = STAT_EMPTY;
         end
      end
      if (cmd.srt_finish) begin
         rsp_in.shift_count = shift_ff;
      end
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rptr_ff      <= rptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      gap_ff   <= gap_in;
      r_ff     <= r_in;
      j_ff     <= j_in;
      i_ff     <= i_in;
      held_ff  <= held_in;
      shift_ff <= shift_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/sspg_ctrl.sv
module sspg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sspg_pkg::kind_type    kind,
   input  sspg_pkg::dp_stat_type stat,
   output sspg_pkg::dp_cmd_type  cmd,
   output logic                  busy
);
   import sspg_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_RDWAIT = 8'b0000_0010,
      ST_SMOOTH = 8'b0000_0100,
      ST_RDJ    = 8'b0000_1000,
      ST_HELD   = 8'b0001_0000,
      ST_CMP    = 8'b0010_0000,
      ST_PUT    = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind)
                  KIND_PUSH: begin
                     cmd.do_push = 1'b1;
                  end
                  KIND_SORT: begin
                     cmd.srt_init = 1'b1;
                     state_in     = stat.few ? ST_FIN : ST_SMOOTH;
                  end
                  KIND_READ: begin
                     cmd.rd_issue = 1'b1;
                     state_in     = ST_RDWAIT;
                  end
                  KIND_CLEAR: begin
                     cmd.do_clear = 1'b1;
                  end
                  default: begin
                     cmd.do_clear = 1'b1;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            cmd.rd_finish = 1'b1;
            state_in      = ST_IDLE;
         end
         // strip factors of two and three until one is left, else step to the next lower gap
         ST_SMOOTH: begin
            if (stat.r_one) begin
               cmd.j_init = 1'b1;
               state_in   = ST_RDJ;
            end else if (stat.r_even || stat.r_div3) begin
               cmd.smooth_step = 1'b1;
            end else if (stat.gap_one) begin
               state_in = ST_FIN;
            end else begin
               cmd.gap_dec = 1'b1;
            end
         end
         ST_RDJ: begin
            cmd.rd_j = 1'b1;
            state_in = ST_HELD;
         end
         ST_HELD: begin
            cmd.held_load = 1'b1;
            state_in      = ST_CMP;
         end
         // gapped insertion: shift while the neighbor is larger
         ST_CMP: begin
            cmd.cmp_step = 1'b1;
            if (stat.greater) begin
               if (!stat.more) begin
                  state_in = ST_PUT;
               end
            end else if (!stat.j_last) begin
               cmd.j_adv = 1'b1;
               state_in  = ST_RDJ;
            end else if (stat.gap_one) begin
               state_in = ST_FIN;
            end else begin
               cmd.gap_dec = 1'b1;
               state_in    = ST_SMOOTH;
            end
         end
         ST_PUT: begin
            cmd.put = 1'b1;
            if (!stat.j_last) begin
               cmd.j_adv = 1'b1;
               state_in  = ST_RDJ;
            end else if (stat.gap_one) begin
               state_in = ST_FIN;
            end else begin
               cmd.gap_dec = 1'b1;
               state_in    = ST_SMOOTH;
            end
         end
         ST_FIN: begin
            cmd.srt_finish = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hw/rtl/shell_sort_pratt_gaps_top.sv
// push and clear: result beat in the cycle after the start beat; read: after ST_RDWAIT
// sort: ST_SMOOTH steps per gap below the count, then ST_FIN
//   + per element of each pass ST_RDJ, ST_HELD and ST_CMP, staying in ST_CMP per shift
// one command at a time, busy until its result is loaded; the store's single
//   read and write port bounds the sort; the receiver cannot stall results
// synchronous reset clears count, read pointer, controller and strobe, not the store
`include "shell_sort_pratt_gaps_top_defines.svh"

module shell_sort_pratt_gaps_top #(
   parameter int DEPTH = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sspg_pkg::req_type req_data,
   output logic              rsp_valid,
   output sspg_pkg::rsp_type rsp_data
);
   import sspg_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        accept;
   logic        short_cmd;
   logic        read_cmd;
   logic        rsp_err;
   logic        rsp_zero;

   // sequencer
   sspg_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_data.kind),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // store, sort registers and result beat
   sspg_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .push_value (req_data.value_in),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // accepted beats and error results for the checks
   assign accept    = start && !busy;
   assign short_cmd = accept && (req_data.kind == KIND_PUSH || req_data.kind == KIND_CLEAR);
   assign read_cmd  = accept && (req_data.kind == KIND_READ);
   assign rsp_err   = rsp_valid && (rsp_data.status != STAT_OK);
   assign rsp_zero  = (rsp_data.value_out == '0) && (rsp_data.shift_count == '0) &&
                      !rsp_data.last_element;

   // checks
   `SSPG_ASSERT_NEXT(a_short_rsp, clock, reset, short_cmd, rsp_valid)
   `SSPG_ASSERT_LATER(a_read_rsp, clock, reset, read_cmd, rsp_valid)
   `SSPG_ASSERT_IMPL(a_err_zero, clock, reset, rsp_err, rsp_zero)
   `SSPG_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy)

endmodule

>>> verif/tb_top.sv
module tb_top;
   import sspg_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int ITEM_TARGET = 1650;
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int TAIL_CYCLES = 16;
   localparam int MAX_REPORTS = 10;
   localparam logic signed [63:0] MAX_VAL = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN_VAL = 64'sh8000_0000_0000_0000;

   // expected-reply bookkeeping plus a private copy of the sorted store
   class shell_sort_checker;
      logic signed [63:0] store_mem [STORE_DEPTH];
      int elem_count;
      int rd_ptr;
      rsp_type expected_replies [$];
      int mismatches;

      function new();
         elem_count = 0;
         rd_ptr = 0;
         mismatches = 0;
      endfunction

      // gap qualifies when it is 2^p * 3^q
      function bit is_3smooth(int g);
         if (g <= 0)
            return 0;
         while (g % 2 == 0)
            g = g / 2;
         while (g % 3 == 0)
            g = g / 3;
         return g == 1;
      endfunction

      // in-place shell sort over the stored elements, returns the shift count
      function logic [31:0] run_shell_sort();
         longint unsigned shifts;
         int gap;
         int j;
         int i;
         logic signed [63:0] held;
         shifts = 0;
         for (gap = elem_count - 1; gap >= 1; gap--) begin
            if (!is_3smooth(gap))
               continue;
            for (j = gap; j < elem_count; j++) begin
               held = store_mem[j];
               i = j;
               while (i >= gap && store_mem[i - gap] > held) begin
                  store_mem[i] = store_mem[i - gap];
                  i = i - gap;
                  shifts++;
               end
               store_mem[i] = held;
            end
         end
         return (shifts > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : shifts[31:0];
      endfunction

      // apply one command to the private state and form its reply
      function rsp_type predict_reply(req_type cmd);
         rsp_type r;
         r = '0;
         case (cmd.kind)
            KIND_PUSH: begin
               if (elem_count >= STORE_DEPTH) begin
                  r.status = STAT_FULL;
               end else begin
                  store_mem[elem_count] = cmd.value_in;
                  elem_count++;
               end
            end
            KIND_SORT: begin
               r.shift_count = run_shell_sort();
               rd_ptr = 0;
            end
            KIND_READ: begin
               if (rd_ptr >= elem_count) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.value_out = store_mem[rd_ptr];
                  r.last_element = (rd_ptr + 1 == elem_count);
                  rd_ptr++;
               end
            end
            default: begin
               elem_count = 0;
               rd_ptr = 0;
            end
         endcase
         return r;
      endfunction

      function void note_command(req_type cmd);
         expected_replies.push_back(predict_reply(cmd));
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
      endfunction

      // compare one result beat with the oldest expected reply
      function void check_beat(rsp_type got);
         rsp_type want;
         if (expected_replies.size() == 0) begin
            flag($sformatf("unexpected result beat value_out=%h status=%0d",
                           got.value_out, got.status));
            return;
         end
         want = expected_replies.pop_front();
         if (got.value_out !== want.value_out)
            flag($sformatf("value_out expected %h got %h", want.value_out, got.value_out));
         if (got.shift_count !== want.shift_count)
            flag($sformatf("shift_count expected %0d got %0d",
                           want.shift_count, got.shift_count));
         if (got.last_element !== want.last_element)
            flag($sformatf("last_element expected %b got %b",
                           want.last_element, got.last_element));
         if (got.status !== want.status)
            flag($sformatf("status expected %0d got %0d", want.status, got.status));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   shell_sort_checker sorter_check = new();
   int items_sent = 0;
   int idle_cycles = 0;
   bit no_gaps = 0;

   shell_sort_pratt_gaps_top #(.DEPTH(STORE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sorter_check.check_beat(rsp_data);
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic logic signed [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // push values: corners, small duplicates, 32-bit range, full range
   function automatic logic signed [63:0] pick_value();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: return MAX_VAL;
               1: return MIN_VAL;
               2: return 64'sd0;
               default: return -64'sd1;
            endcase
         end
         1: return $signed({60'd0, 4'($urandom_range(0, 15))}) - 64'sd8;
         2: return {{32{w[31]}}, w};
         default: return rand_word();
      endcase
   endfunction

   // present one command and hold it until the block takes the beat
   task automatic send_cmd(kind_type k, logic signed [63:0] v);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{kind: k, value_in: v};
      do
         @(posedge clock);
      while (busy);
      sorter_check.note_command('{kind: k, value_in: v});
      items_sent++;
   endtask

   // hold off the sender until every reply is back
   task automatic wait_for_replies();
      start <= 1'b0;
      do
         @(posedge clock);
      while (sorter_check.expected_replies.size() != 0);
   endtask

   // corner cases on tiny sets
   task automatic directed_phase();
      send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_SORT, rand_word());
      send_cmd(KIND_PUSH, MAX_VAL);
      send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_SORT, rand_word());
      send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_CLEAR, rand_word());
      send_cmd(KIND_PUSH, MIN_VAL);
      send_cmd(KIND_PUSH, MAX_VAL);
      send_cmd(KIND_PUSH, -64'sd1);
      send_cmd(KIND_PUSH, 64'sd0);
      send_cmd(KIND_PUSH, 64'sd1);
      send_cmd(KIND_PUSH, MIN_VAL);
      // unsorted read returns stored order
      send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_SORT, rand_word());
      repeat (3) send_cmd(KIND_READ, rand_word());
      // append after reads keeps the pointer
      send_cmd(KIND_PUSH, 64'sd5);
      repeat (5) send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_CLEAR, rand_word());
      send_cmd(KIND_READ, rand_word());
   endtask

   // fill the store to the top, overflow it, sort the full set
   task automatic full_store_phase();
      send_cmd(KIND_CLEAR, rand_word());
      repeat (STORE_DEPTH) send_cmd(KIND_PUSH, pick_value());
      repeat (2) send_cmd(KIND_PUSH, pick_value());
      send_cmd(KIND_SORT, rand_word());
      repeat (6) send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_PUSH, pick_value());
      send_cmd(KIND_READ, rand_word());
      send_cmd(KIND_CLEAR, rand_word());
   endtask

   // well-formed load, sort, read-back set with occasional stray commands
   task automatic run_set();
      int n;
      int pattern;
      int k;
      int extra;
      logic signed [63:0] base;
      logic signed [63:0] v;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      pattern = $urandom_range(0, 3);
      base = pick_value();
      if ($urandom_range(0, 4) != 0)
         send_cmd(KIND_CLEAR, rand_word());
      for (k = 0; k < n; k++) begin
         case (pattern)
            0: v = pick_value();
            1: v = base + k;
            2: v = base - k;
            default: v = base;
         endcase
         send_cmd(KIND_PUSH, v);
      end
      if ($urandom_range(0, 9) != 0)
         send_cmd(KIND_SORT, rand_word());
      extra = $urandom_range(0, 2);
      for (k = 0; k < n + extra; k++) begin
         case ($urandom_range(0, 29))
            0: send_cmd(KIND_PUSH, pick_value());
            1: send_cmd(KIND_SORT, rand_word());
            default: ;
         endcase
         send_cmd(KIND_READ, rand_word());
      end
   endtask

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      directed_phase();
      wait_for_replies();
      full_store_phase();

      while (items_sent < ITEM_TARGET) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 5) == 0)
            wait_for_replies();
         if ($urandom_range(0, 9) < 7) begin
            run_set();
         end else begin
            repeat ($urandom_range(1, 8))
               send_cmd(kind_type'($urandom_range(0, 3)), pick_value());
         end
      end

      // drain and settle
      wait_for_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sorter_check.mismatches == 0 && sorter_check.expected_replies.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
